// ===== rtl/wgm_pkg.sv =====
// Shared types, microcode field codes and the exp2 factor table for the geometric-mean block.
package wgm_pkg;

    // Datapath operations selected by the control word.
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_LOG_SQ   = 3'd2;
    localparam logic [2:0] OP_TERM_MUL = 3'd3;
    localparam logic [2:0] OP_ACC      = 3'd4;
    localparam logic [2:0] OP_EXP_STEP = 3'd5;
    localparam logic [2:0] OP_EMIT     = 3'd6;

    // Conditions under which a step holds in place.
    localparam logic [1:0] HOLD_NONE   = 2'd0;
    localparam logic [1:0] HOLD_INPUT  = 2'd1;
    localparam logic [1:0] HOLD_OUTPUT = 2'd2;

    // Jump conditions; when false the step counter advances by one.
    localparam logic [1:0] COND_NEVER    = 2'd0;
    localparam logic [1:0] COND_ALWAYS   = 2'd1;
    localparam logic [1:0] COND_LOOP     = 2'd2;
    localparam logic [1:0] COND_NOT_LAST = 2'd3;

    localparam int PC_W  = 3;
    localparam int IDX_W = 4;

    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      hold_sel;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic [2:0]       op;
        logic             fire;
        logic [IDX_W-1:0] idx;
    } ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic last;
        logic out_busy;
    } stat_t;

    typedef logic [15:0][30:0] fac_tbl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = 64'd0;
        bit_v = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Entry k holds 2^(-2^-(k+1)) in Q1.30, built as a floored square-root chain.
    function automatic fac_tbl_t exp_factor_table();
        fac_tbl_t    tbl;
        logic [63:0] c;
        c = isqrt64(64'h1 << 59);
        for (int k = 0; k < 16; k++) begin
            tbl[k] = c[30:0];
            c      = isqrt64(c << 30);
        end
        return tbl;
    endfunction

    localparam fac_tbl_t EXP_FACTORS = exp_factor_table();

endpackage

// ===== rtl/wgm_sequencer.sv =====
// Microcode sequencer: program ROM, step counter, loop counter and handshake holds.
module wgm_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  wgm_pkg::stat_t stat,
    output wgm_pkg::ctrl_t ctrl
);

    localparam logic [wgm_pkg::PC_W-1:0] STEP_LOAD = 3'd0;
    localparam logic [wgm_pkg::PC_W-1:0] STEP_SQ   = 3'd1;
    localparam logic [wgm_pkg::PC_W-1:0] STEP_MUL  = 3'd2;
    localparam logic [wgm_pkg::PC_W-1:0] STEP_ACC  = 3'd3;
    localparam logic [wgm_pkg::PC_W-1:0] STEP_EXP  = 3'd4;
    localparam logic [wgm_pkg::PC_W-1:0] STEP_EMIT = 3'd5;

    localparam wgm_pkg::uword_t UCODE [8] = '{
        '{wgm_pkg::OP_LOAD,     wgm_pkg::HOLD_INPUT,  wgm_pkg::COND_NEVER,    STEP_LOAD},
        '{wgm_pkg::OP_LOG_SQ,   wgm_pkg::HOLD_NONE,   wgm_pkg::COND_LOOP,     STEP_SQ},
        '{wgm_pkg::OP_TERM_MUL, wgm_pkg::HOLD_NONE,   wgm_pkg::COND_NEVER,    STEP_LOAD},
        '{wgm_pkg::OP_ACC,      wgm_pkg::HOLD_NONE,   wgm_pkg::COND_NOT_LAST, STEP_LOAD},
        '{wgm_pkg::OP_EXP_STEP, wgm_pkg::HOLD_NONE,   wgm_pkg::COND_LOOP,     STEP_EXP},
        '{wgm_pkg::OP_EMIT,     wgm_pkg::HOLD_OUTPUT, wgm_pkg::COND_ALWAYS,   STEP_LOAD},
        '{wgm_pkg::OP_NOP,      wgm_pkg::HOLD_NONE,   wgm_pkg::COND_ALWAYS,   STEP_LOAD},
        '{wgm_pkg::OP_NOP,      wgm_pkg::HOLD_NONE,   wgm_pkg::COND_ALWAYS,   STEP_LOAD}
    };

    logic [wgm_pkg::PC_W-1:0]  pc_reg;
    logic [wgm_pkg::PC_W-1:0]  pc_next;
    logic [wgm_pkg::IDX_W-1:0] cnt_reg;
    logic [wgm_pkg::IDX_W-1:0] cnt_next;
    wgm_pkg::uword_t           uw;
    logic                      hold;
    logic                      jump;

    assign uw = UCODE[pc_reg];

    always_comb begin
        unique case (uw.hold_sel)
            wgm_pkg::HOLD_NONE:   hold = 1'b0;
            wgm_pkg::HOLD_INPUT:  hold = !in_valid;
            wgm_pkg::HOLD_OUTPUT: hold = stat.out_busy;
            default:              hold = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            wgm_pkg::COND_NEVER:    jump = 1'b0;
            wgm_pkg::COND_ALWAYS:   jump = 1'b1;
            wgm_pkg::COND_LOOP:     jump = (cnt_reg != '0);
            wgm_pkg::COND_NOT_LAST: jump = !stat.last;
            default:                jump = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            pc_next  = pc_reg;
            cnt_next = cnt_reg;
        end else begin
            pc_next  = jump ? uw.target : pc_reg + 1'b1;
            // Loop steps count down; every other step rearms the count.
            cnt_next = (uw.cond == wgm_pkg::COND_LOOP) ? cnt_reg - 1'b1 : '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pc_reg  <= STEP_LOAD;
            cnt_reg <= '1;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign in_stall  = (uw.hold_sel != wgm_pkg::HOLD_INPUT);
    assign ctrl.op   = uw.op;
    assign ctrl.fire = !hold;
    assign ctrl.idx  = cnt_reg;

endmodule

// ===== rtl/wgm_datapath.sv =====
// Datapath: log2 by squaring, weighted accumulate, exp2 by factor products, output register.
module wgm_datapath #(
    parameter int MAX_TERMS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wgm_pkg::ctrl_t ctrl,
    output wgm_pkg::stat_t stat,
    input  logic [15:0]    score,
    input  logic [16:0]    weight,
    input  logic           score_is_one,
    input  logic           checks_ok,
    input  logic           last,
    input  logic [16:0]    threshold,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [16:0]    mu,
    output logic           go_flag
);

    localparam int TERM_W = $clog2(MAX_TERMS + 1);

    logic [16:0]       weight_reg;
    logic              one_reg;
    logic              ok_reg;
    logic              last_reg;
    logic [3:0]        e_reg;
    logic [3:0]        e_next;
    logic [30:0]       m_reg;
    logic [30:0]       m_next;
    logic [15:0]       frac_reg;
    logic [15:0]       frac_next;
    logic [37:0]       prod_reg;
    logic [37:0]       prod_next;
    logic [25:0]       accum_reg;
    logic [25:0]       accum_next;
    logic [TERM_W-1:0] count_reg;
    logic [TERM_W-1:0] count_next;
    logic [30:0]       r_reg;
    logic [30:0]       r_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [16:0]       mu_reg;
    logic [16:0]       mu_next;
    logic              go_reg;
    logic              go_next;

    logic [15:0]       s_clamp;
    logic [3:0]        lead;
    logic [30:0]       m_norm;
    logic [4:0]        int_part;
    logic [20:0]       t_mag;
    logic [30:0]       mul_a;
    logic [30:0]       mul_b;
    logic [61:0]       mul_p;
    logic [31:0]       sq_top;
    logic [61:0]       exp_rnd;
    logic [38:0]       term_rnd;
    logic [26:0]       acc_sum;
    logic [9:0]        n_int;
    logic [5:0]        rsh;
    logic [30:0]       r_shr;
    logic [17:0]       mu_half;
    logic [16:0]       mu_calc;
    logic              do_load;

    assign do_load = ctrl.fire && (ctrl.op == wgm_pkg::OP_LOAD);

    always_comb begin
        s_clamp = (score == 16'd0) ? 16'd1 : score;
        lead    = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (s_clamp[i]) begin
                lead = 4'(i);
            end
        end
        m_norm = {15'd0, s_clamp} << (5'd30 - {1'b0, lead});
    end

    // Integer part of -log2 is 16 minus the leading-one position.
    assign int_part = 5'd16 - {1'b0, e_reg};
    assign t_mag    = one_reg ? 21'd0 : ({int_part, 16'd0} - {5'd0, frac_reg});

    // One shared multiplier; its product is always registered before reuse.
    always_comb begin
        unique case (ctrl.op)
            wgm_pkg::OP_LOG_SQ: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            wgm_pkg::OP_TERM_MUL: begin
                mul_a = {14'd0, weight_reg};
                mul_b = {10'd0, t_mag};
            end
            wgm_pkg::OP_EXP_STEP: begin
                mul_a = r_reg;
                mul_b = wgm_pkg::EXP_FACTORS[4'd15 - ctrl.idx];
            end
            default: begin
                mul_a = m_reg;
                mul_b = r_reg;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign sq_top   = mul_p[61:30];
    assign exp_rnd  = mul_p + (62'd1 << 29);
    assign term_rnd = {1'b0, prod_reg} + 39'd32768;
    assign acc_sum  = {1'b0, accum_reg} + {4'd0, term_rnd[38:16]};

    // mu = (r + 2^(13+n)) >> (14+n), done as a shift, an increment and a halving.
    assign n_int   = accum_reg[25:16];
    assign rsh     = n_int[5:0] + 6'd13;
    assign r_shr   = r_reg >> rsh;
    assign mu_half = r_shr[17:0] + 18'd1;
    assign mu_calc = (n_int > 10'd40) ? 17'd0 : mu_half[17:1];

    always_comb begin
        e_next         = e_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        accum_next     = accum_reg;
        count_next     = count_reg;
        r_next         = r_reg;
        mu_next        = mu_reg;
        go_next        = go_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (ctrl.fire) begin
            unique case (ctrl.op)
                wgm_pkg::OP_LOAD: begin
                    e_next    = lead;
                    m_next    = m_norm;
                    frac_next = 16'd0;
                end
                wgm_pkg::OP_LOG_SQ: begin
                    if (sq_top[31]) begin
                        m_next              = sq_top[31:1];
                        frac_next[ctrl.idx] = 1'b1;
                    end else begin
                        m_next = sq_top[30:0];
                    end
                end
                wgm_pkg::OP_TERM_MUL: begin
                    prod_next = mul_p[37:0];
                end
                wgm_pkg::OP_ACC: begin
                    if (count_reg < TERM_W'(MAX_TERMS)) begin
                        accum_next = acc_sum[26] ? '1 : acc_sum[25:0];
                        count_next = count_reg + 1'b1;
                    end
                    r_next = 31'h4000_0000;
                end
                wgm_pkg::OP_EXP_STEP: begin
                    if (accum_reg[ctrl.idx]) begin
                        r_next = exp_rnd[60:30];
                    end
                end
                wgm_pkg::OP_EMIT: begin
                    mu_next        = mu_calc;
                    go_next        = (mu_calc >= threshold) && ok_reg;
                    out_valid_next = 1'b1;
                    accum_next     = '0;
                    count_next     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            accum_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_load) begin
            weight_reg <= weight;
            one_reg    <= score_is_one;
            ok_reg     <= checks_ok;
            last_reg   <= last;
        end
        e_reg    <= e_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        mu_reg   <= mu_next;
        go_reg   <= go_next;
    end

    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign mu            = mu_reg;
    assign go_flag       = go_reg;

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && ctrl.op == wgm_pkg::OP_EMIT) |=> (accum_reg == '0 && count_reg == '0))
        else $error("accumulator not cleared after a result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TERM_W'(MAX_TERMS))
        else $error("term count beyond limit");

    a_mu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mu_reg <= 17'h10000))
        else $error("mu above one");

    a_go_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && ctrl.op == wgm_pkg::OP_EMIT) |=> (!go_reg || ok_reg))
        else $error("go decision without checks ok");

endmodule

// ===== rtl/weighted_geomean_threshold_top.sv =====
// Top level of the weighted geometric-mean go/halt block.
//
//  channel   signals                                           direction
//  input     in_valid, in_stall, score, weight, score_is_one,  in (stall out)
//            checks_ok, last
//  output    out_valid, out_stall, mu, go_flag                 out (stall in)
//  config    cfg_wr_en, cfg_wr_data (harmony threshold)        in
//
// A term runs a load step, 16 squaring passes of the shared
// multiplier for log2, one weight multiply and one accumulate.
// A term marked last then adds 16 exp2 factor products and one emit step.
// The emit step holds while the previous result is still stalled; input
// transfers continue meanwhile up to that point.
// Reset clears the accumulator, the term count and the output valid, and
// loads the threshold with 0.9995.
module weighted_geomean_threshold_top #(
    parameter int MAX_TERMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] score,
    input  logic [16:0] weight,
    input  logic        score_is_one,
    input  logic        checks_ok,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] mu,
    output logic        go_flag,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    logic [16:0]    threshold_reg;
    wgm_pkg::ctrl_t ctrl;
    wgm_pkg::stat_t stat;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold_reg <= 17'd65503;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    wgm_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    wgm_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .score        (score),
        .weight       (weight),
        .score_is_one (score_is_one),
        .checks_ok    (checks_ok),
        .last         (last),
        .threshold    (threshold_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mu           (mu),
        .go_flag      (go_flag)
    );

endmodule

// ===== dv/weighted_geomean_threshold_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the weighted geometric-mean go/halt block.
module weighted_geomean_threshold_top_tb;

    localparam int          TERM_LIMIT     = 16;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [16:0] THR_RESET      = 17'd65503;
    localparam logic [16:0] Q16_ONE        = 17'd65536;
    localparam logic [25:0] LOG_SUM_MAX    = 26'h3FF_FFFF;

    typedef struct packed {
        logic [15:0] score;
        logic [16:0] weight;
        logic        is_one;
        logic        ok;
        logic        last;
    } term_t;

    typedef struct packed {
        logic [16:0] mu;
        logic        go;
    } verdict_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [15:0] score        = '0;
    logic [16:0] weight       = '0;
    logic        score_is_one = 1'b0;
    logic        checks_ok    = 1'b0;
    logic        last         = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [16:0] mu;
    logic        go_flag;
    logic        cfg_wr_en    = 1'b0;
    logic [16:0] cfg_wr_data  = '0;

    term_t    pending_terms[$];
    verdict_t expected_verdicts[$];
    term_t    on_bus;
    int       terms_queued   = 0;
    int       terms_accepted = 0;
    int       mismatch_count = 0;
    int       in_idle_pct    = 10;
    int       out_stall_pct  = 10;

    // Shadow copy of the block state.
    logic [25:0] log_sum      = '0;
    logic [6:0]  terms_taken  = '0;
    logic [16:0] go_threshold = THR_RESET;

    weighted_geomean_threshold_top #(
        .MAX_TERMS(TERM_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .score       (score),
        .weight      (weight),
        .score_is_one(score_is_one),
        .checks_ok   (checks_ok),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mu          (mu),
        .go_flag     (go_flag),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Magnitude of log2(s / 2^16) in Q.16, with a zero score taken as one LSB.
    function automatic logic [20:0] log2_depth(input logic [15:0] s);
        logic [15:0] x;
        logic [63:0] m;
        logic [15:0] frac;
        int          msb;
        x    = (s == 16'd0) ? 16'd1 : s;
        msb  = 15;
        frac = '0;
        while (!x[msb])
            msb--;
        m = 64'(x) << (30 - msb);
        // Each squaring of the Q1.30 mantissa yields one fraction bit.
        for (int i = 1; i <= 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[16 - i] = 1'b1;
            end
        end
        return 21'((16 - msb) * 65536 - int'(frac));
    endfunction

    // 2^-acc in Q1.16, built from the square-root chain of factors.
    function automatic logic [16:0] mean_from_log(input logic [25:0] acc);
        logic [63:0] r;
        logic [63:0] c;
        int          n;
        n = int'(acc[25:16]);
        r = 64'd1 << 30;
        c = floor_sqrt(64'd1 << 59);
        for (int k = 1; k <= 16; k++)
        begin
            if (acc[16 - k])
                r = (r * c + (64'd1 << 29)) >> 30;
            c = floor_sqrt(c << 30);
        end
        if (n > 40)
            return '0;
        return 17'((r + (64'd1 << (13 + n))) >> (14 + n));
    endfunction

    task automatic take_term(input term_t t);
        logic [20:0] depth;
        logic [63:0] contrib;
        logic [63:0] total;
        verdict_t    v;
        terms_accepted++;
        if (terms_taken < TERM_LIMIT)
        begin
            depth   = t.is_one ? '0 : log2_depth(t.score);
            contrib = (64'(t.weight) * 64'(depth) + 64'd32768) >> 16;
            total   = 64'(log_sum) + contrib;
            log_sum = (total > 64'(LOG_SUM_MAX)) ? LOG_SUM_MAX : total[25:0];
            terms_taken++;
        end
        if (t.last)
        begin
            v.mu = mean_from_log(log_sum);
            v.go = (v.mu >= go_threshold) && t.ok;
            expected_verdicts.push_back(v);
            log_sum     = '0;
            terms_taken = '0;
        end
    endtask

    task automatic push_term(input logic [15:0] s, input logic [16:0] w,
                             input bit one, input bit ok, input bit fin);
        term_t t;
        t.score  = s;
        t.weight = w;
        t.is_one = one;
        t.ok     = ok;
        t.last   = fin;
        pending_terms.push_back(t);
        terms_queued++;
    endtask

    // One frame of terms closed by a last term; a tenth run from one under to four over the term limit.
    task automatic queue_frame(input bit healthy);
        int          n;
        bit          one;
        logic [15:0] s;
        logic [16:0] w;
        n = ($urandom_range(99) < 10) ? $urandom_range(TERM_LIMIT + 4, TERM_LIMIT - 1)
                                      : $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
        begin
            if (healthy)
            begin
                one = ($urandom_range(99) < 40);
                s   = 16'($urandom_range(65535, 65400));
                w   = 17'($urandom_range(16384, 0));
            end
            else
            begin
                one = ($urandom_range(99) < 10);
                s   = 16'($urandom);
                w   = ($urandom_range(99) < 80) ? 17'($urandom_range(65536, 0))
                                                : 17'($urandom_range(131071, 65536));
            end
            push_term(s, w, one, $urandom_range(99) < 85, i == n - 1);
        end
    endtask

    task automatic wait_idle();
        while (terms_accepted != terms_queued || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [16:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        go_threshold  = value;
    endtask

    // Input driver: a stalled transfer holds its payload until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_term(on_bus);
            if (!in_valid || !in_stall)
            begin
                if (pending_terms.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    on_bus        = pending_terms.pop_front();
                    in_valid     <= 1'b1;
                    score        <= on_bus.score;
                    weight       <= on_bus.weight;
                    score_is_one <= on_bus.is_one;
                    checks_ok    <= on_bus.ok;
                    last         <= on_bus.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual mu %0d go %0b",
                             $time, mu, go_flag);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (mu !== want.mu)
                    begin
                        $display("%0t: mu mismatch: expected %0d, actual %0d",
                                 $time, want.mu, mu);
                        mismatch_count++;
                    end
                    if (go_flag !== want.go)
                    begin
                        $display("%0t: go_flag mismatch: expected %0b, actual %0b",
                                 $time, want.go, go_flag);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[weighted_geomean_threshold_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [16:0] thr_value;
        int          phase_goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset threshold.
        push_term(16'd0, Q16_ONE, 1'b1, 1'b1, 1'b1);
        push_term(16'hFFFF, Q16_ONE, 1'b1, 1'b0, 1'b1);
        push_term(16'd0, Q16_ONE, 1'b0, 1'b1, 1'b1);
        push_term(16'd1, Q16_ONE, 1'b0, 1'b1, 1'b1);
        push_term(16'hFFFF, Q16_ONE, 1'b0, 1'b1, 1'b1);
        push_term(16'd0, 17'd0, 1'b0, 1'b1, 1'b1);
        push_term(16'h8000, 17'h1FFFF, 1'b0, 1'b1, 1'b1);
        push_term(16'd40000, 17'd32768, 1'b0, 1'b1, 1'b0);
        push_term(16'd50000, 17'd32768, 1'b0, 1'b1, 1'b1);
        // The closing term falls past the term limit and must add nothing.
        for (int i = 0; i < TERM_LIMIT; i++)
            push_term(16'($urandom), Q16_ONE, 1'b0, 1'b1, 1'b0);
        push_term(16'd0, 17'h1FFFF, 1'b0, 1'b1, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       thr_value = '0;
                1:       thr_value = Q16_ONE;
                2:       thr_value = 17'h1FFFF;
                3:       thr_value = 17'($urandom_range(65536, 60000));
                default: thr_value = THR_RESET;
            endcase
            set_threshold(thr_value);
            // One phase runs back to back with no gaps on either side.
            in_idle_pct   = (ph == 2) ? 0 : 10;
            out_stall_pct = (ph == 2) ? 0 : 10;
            phase_goal    = terms_queued + 240;
            while (terms_queued < phase_goal)
                queue_frame($urandom_range(99) < 40);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("[weighted_geomean_threshold_top] OK");
        else
            $display("[weighted_geomean_threshold_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wgm_pkg.sv
rtl/wgm_sequencer.sv
rtl/wgm_datapath.sv
rtl/weighted_geomean_threshold_top.sv
dv/weighted_geomean_threshold_top_tb.sv
